FILE: src/srall_pkg.sv
// Shared types and constants for the streaming substring replace block.
`default_nettype none

package srall_pkg;

  localparam int BYTE_W = 8;
  localparam int REG_W = 64;
  localparam int LEN_W = 5;
  localparam int REG_IDX_W = 3;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_REPLACEMENT_DEF = 16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAT_LO,
    REG_PAT_HI,
    REG_PAT_LEN,
    REG_REP_LO,
    REG_REP_HI,
    REG_REP_LEN,
    REG_SPARE_6,
    REG_SPARE_7
  } reg_index_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/substring_replace_all.sv
// Top level of the streaming substring replace block.
`default_nettype none

// Replaces every leftmost, non-overlapping occurrence of a configured pattern
// (up to MAX_PATTERN bytes) in a byte stream with a configured replacement
// (up to MAX_REPLACEMENT bytes). Bytes are held in a row of cells until a full
// pattern length is present. A word that completes a window is compared; on a
// match the replacement bytes are sent, else the oldest byte is sent and the
// window shifts. The final word of a string flushes each byte still held in
// the window. With an empty pattern every word passes straight through. The
// single sequencer drives one output register, at most one result word per
// cycle while the output is not stalled, and takes no new input word until it
// is idle again. Configuration is to be written only while the block is idle;
// the block itself does not enforce this. Writing the pattern length empties
// the window.
module substring_replace_all #(
  parameter int MAX_PATTERN = srall_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = srall_pkg::MAX_REPLACEMENT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [srall_pkg::REG_IDX_W-1:0]    wr_index,
  input  wire logic [srall_pkg::REG_W-1:0]        wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [srall_pkg::BYTE_W-1:0]       in_byte,
  input  wire logic                               end_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [srall_pkg::BYTE_W-1:0]       out_byte,
  output logic                                    byte_valid,
  output logic                                    end_out
);

  localparam int BW = srall_pkg::BYTE_W;
  localparam int LW = srall_pkg::LEN_W;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int RIDX_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_REPL,
    S_FLUSH
  } state_t;

  logic [srall_pkg::REG_W-1:0] pattern_low;
  logic [srall_pkg::REG_W-1:0] pattern_high;
  logic [LW-1:0]               pattern_length;
  logic [srall_pkg::REG_W-1:0] replacement_low;
  logic [srall_pkg::REG_W-1:0] replacement_high;
  logic [LW-1:0]               replacement_length;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [RIDX_W-1:0] ridx;
  logic              end_flag;

  logic [2*srall_pkg::REG_W-1:0] pat_word;
  logic [2*srall_pkg::REG_W-1:0] rep_word;
  logic [LW-1:0]     plen;
  logic [LW-1:0]     rlen;
  logic              can_emit;
  logic              accept;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  new_count;
  logic              match;
  logic              repl_last;
  logic              emit;
  logic [BW-1:0]     emit_byte;
  logic              emit_bv;
  logic              emit_end;
  logic              shift;
  logic              load;

  logic [BW-1:0]          cell_data [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_eq;
  logic [MAX_PATTERN-1:0] cell_off;

  assign pat_word = {pattern_high, pattern_low};
  assign rep_word = {replacement_high, replacement_low};
  assign plen = (pattern_length > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : pattern_length;
  assign rlen = (replacement_length > LW'(MAX_REPLACEMENT)) ?
                LW'(MAX_REPLACEMENT) : replacement_length;

  assign can_emit = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && can_emit);
  assign accept = in_valid && !in_stall;
  assign idx = (LW'(count) >= plen) ? '0 : count;
  assign new_count = idx + CNT_W'(1);
  assign match = &(cell_eq | cell_off);
  assign repl_last = (LW'(ridx) == (rlen - LW'(1)));

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    srall_pkg::cell_ctrl_t ctrl;
    logic [BW-1:0] right_byte;

    assign ctrl.shift = shift;
    assign ctrl.load = load && (idx == CNT_W'(k));
    assign cell_off[k] = (LW'(k) >= plen);

    if (k == MAX_PATTERN - 1) begin : g_last
      assign right_byte = '0;
    end else begin : g_mid
      assign right_byte = cell_data[k+1];
    end

    srall_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_byte  (in_byte),
      .right_byte (right_byte),
      .pat_byte   (pat_word[BW*k +: BW]),
      .data       (cell_data[k]),
      .eq         (cell_eq[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low <= '0;
      pattern_high <= '0;
      pattern_length <= '0;
      replacement_low <= '0;
      replacement_high <= '0;
      replacement_length <= '0;
    end else if (wr_en) begin
      case (wr_index)
        srall_pkg::REG_PAT_LO:  pattern_low <= wr_data;
        srall_pkg::REG_PAT_HI:  pattern_high <= wr_data;
        srall_pkg::REG_PAT_LEN: pattern_length <= wr_data[LW-1:0];
        srall_pkg::REG_REP_LO:  replacement_low <= wr_data;
        srall_pkg::REG_REP_HI:  replacement_high <= wr_data;
        srall_pkg::REG_REP_LEN: replacement_length <= wr_data[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    emit = 1'b0;
    emit_byte = '0;
    emit_bv = 1'b1;
    emit_end = 1'b0;
    shift = 1'b0;
    load = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (plen == '0) begin
            emit = 1'b1;
            emit_byte = in_byte;
            emit_end = end_in;
          end else begin
            load = 1'b1;
          end
        end
      end
      S_CMP: begin
        if (can_emit) begin
          if (match) begin
            if ((rlen == '0) && end_flag) begin
              emit = 1'b1;
              emit_bv = 1'b0;
              emit_end = 1'b1;
            end
          end else begin
            emit = 1'b1;
            emit_byte = cell_data[0];
            emit_end = end_flag && (count == CNT_W'(1));
            shift = 1'b1;
          end
        end
      end
      S_REPL: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_byte = rep_word[BW*ridx +: BW];
          emit_end = end_flag && repl_last;
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_byte = cell_data[0];
          emit_end = (count == CNT_W'(1));
          shift = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ridx <= '0;
      end_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            end_flag <= end_in;
            if (plen != '0) begin
              count <= new_count;
              if (LW'(new_count) == plen) begin
                state <= S_CMP;
              end else if (end_in) begin
                state <= S_FLUSH;
              end
            end
          end
        end
        S_CMP: begin
          if (can_emit) begin
            if (match) begin
              count <= '0;
              ridx <= '0;
              state <= (rlen != '0) ? S_REPL : S_IDLE;
            end else begin
              count <= count - CNT_W'(1);
              state <= (end_flag && (count != CNT_W'(1))) ? S_FLUSH : S_IDLE;
            end
          end
        end
        S_REPL: begin
          if (can_emit) begin
            ridx <= ridx + RIDX_W'(1);
            if (repl_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (can_emit) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (wr_en && (wr_index == srall_pkg::REG_PAT_LEN)) begin
        count <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      byte_valid <= emit_bv;
      end_out <= emit_end;
    end
  end

`ifndef SYNTH
  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= plen)
    else $error("window fill exceeds the pattern length");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (count != '0))
    else $error("flush running on an empty window");

  a_end_clears_window: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && ($past(state) != S_IDLE) && end_flag) |-> (count == '0))
    else $error("window not empty after the end of a string");
`endif

endmodule

`default_nettype wire

FILE: src/srall_cell.sv
// One byte cell of the pattern window, with its shift path and pattern compare.
`default_nettype none

module srall_cell (
  input  wire logic                            clk,
  input  wire srall_pkg::cell_ctrl_t           ctrl,
  input  wire logic [srall_pkg::BYTE_W-1:0]    load_byte,
  input  wire logic [srall_pkg::BYTE_W-1:0]    right_byte,
  input  wire logic [srall_pkg::BYTE_W-1:0]    pat_byte,
  output logic      [srall_pkg::BYTE_W-1:0]    data,
  output logic                                 eq
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= right_byte;
    end else if (ctrl.load) begin
      data <= load_byte;
    end
  end

  assign eq = (data == pat_byte);

endmodule

`default_nettype wire
